@@ src/frame_index_bcd_msf_convert_core_defines.svh @@
// Assertion macros used by the converter core to check the conversion pipeline.
`ifndef FRAME_INDEX_BCD_MSF_CONVERT_CORE_DEFINES_SVH
`define FRAME_INDEX_BCD_MSF_CONVERT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSF_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSF_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ src/msf_pkg.sv @@
`default_nettype none

package msf_pkg;

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_DECODE = 1'b1
    } msf_req_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } msf_ld_t;

    localparam logic signed [20:0] FRAME_BIAS    = 21'sd150;
    localparam logic signed [20:0] MAX_ABS_FRAME = 21'sd449999;

    // Reciprocal of 75: exact quotient for any count below 2^19.
    localparam logic [18:0] RECIP_75    = 19'd447393;
    localparam int          RECIP_75_SH = 25;
    // Reciprocal of 60: exact quotient for any second count below 6000.
    localparam logic [13:0] RECIP_60    = 14'd8739;
    localparam int          RECIP_60_SH = 19;

    function automatic logic [7:0] unpack_bcd(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // Tens digit by multiplication with 205/2048, exact below 1029.
    function automatic logic [7:0] pack_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - ((7'(tens) << 3) + (7'(tens) << 1));
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

@@ src/msf_encode.sv @@
`default_nettype none

module msf_encode
    import msf_pkg::*;
(
    input  wire logic               clk,
    input  wire msf_ld_t            ld,
    input  wire logic signed [19:0] frame_index,
    output logic [6:0]              minutes,
    output logic [5:0]              seconds,
    output logic [6:0]              frames
);

    logic signed [20:0] biased;
    logic [18:0]        x_next;
    logic [18:0]        x1_reg;
    logic [18:0]        x2_reg;
    logic [37:0]        prod2_reg;
    logic [12:0]        secs_total;
    logic [18:0]        frame_full;
    logic [12:0]        secs3_reg;
    logic [6:0]         frames3_reg;
    logic [26:0]        mprod3_reg;
    logic [6:0]         mins_q;
    logic [12:0]        sec_full;
    logic [6:0]         mins4_reg;
    logic [5:0]         secs4_reg;
    logic [6:0]         frames4_reg;

    always_comb
    begin
        biased = 21'(frame_index) + FRAME_BIAS;
        if (biased[20])
        begin
            x_next = '0;
        end
        else if (biased > MAX_ABS_FRAME)
        begin
            x_next = MAX_ABS_FRAME[18:0];
        end
        else
        begin
            x_next = biased[18:0];
        end
    end

    assign secs_total = prod2_reg[RECIP_75_SH +: 13];
    assign frame_full = x2_reg - 19'(secs_total) * 19'd75;
    assign mins_q     = mprod3_reg[RECIP_60_SH +: 7];
    assign sec_full   = secs3_reg - 13'(mins_q) * 13'd60;

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            x1_reg <= x_next;
        end
        if (ld.s2)
        begin
            x2_reg    <= x1_reg;
            prod2_reg <= 38'(x1_reg) * 38'(RECIP_75);
        end
        if (ld.s3)
        begin
            secs3_reg   <= secs_total;
            frames3_reg <= frame_full[6:0];
            mprod3_reg  <= 27'(secs_total) * 27'(RECIP_60);
        end
        if (ld.s4)
        begin
            mins4_reg   <= mins_q;
            secs4_reg   <= sec_full[5:0];
            frames4_reg <= frames3_reg;
        end
    end

    assign minutes = mins4_reg;
    assign seconds = secs4_reg;
    assign frames  = frames4_reg;

endmodule

`default_nettype wire

@@ src/msf_decode.sv @@
`default_nettype none

module msf_decode
    import msf_pkg::*;
(
    input  wire logic        clk,
    input  wire msf_ld_t     ld,
    input  wire logic [7:0]  minute_bcd,
    input  wire logic [7:0]  second_bcd,
    input  wire logic [7:0]  frame_bcd,
    output logic [20:0]      index_out
);

    logic [7:0]  m1_reg;
    logic [7:0]  s1_reg;
    logic [7:0]  f1_reg;
    logic [13:0] t2_reg;
    logic [7:0]  f2_reg;
    logic [19:0] v3_reg;
    logic [7:0]  f3_reg;
    logic [20:0] idx4_reg;

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            m1_reg <= unpack_bcd(minute_bcd);
            s1_reg <= unpack_bcd(second_bcd);
            f1_reg <= unpack_bcd(frame_bcd);
        end
        if (ld.s2)
        begin
            t2_reg <= 14'(m1_reg) * 14'd60 + 14'(s1_reg);
            f2_reg <= f1_reg;
        end
        if (ld.s3)
        begin
            v3_reg <= 20'(t2_reg) * 20'd75;
            f3_reg <= f2_reg;
        end
        if (ld.s4)
        begin
            idx4_reg <= 21'(v3_reg) + 21'(f3_reg) - 21'(FRAME_BIAS);
        end
    end

    assign index_out = idx4_reg;

endmodule

`default_nettype wire

@@ src/frame_index_bcd_msf_convert_core.sv @@
// Frame index to packed BCD minute:second:frame converter, both directions.
// Input beats arrive on the s_axis channel: tuser selects the request (encode
// a signed frame index, or decode three packed BCD bytes) and tdata carries
// the operands. Each input beat yields exactly one output beat on m_axis,
// with the unused result fields driven to zero.
// The datapath is a five-stage pipeline: each beat passes through the s1 to
// s4 stage registers and then the output register. One beat per cycle is
// taken while the output side keeps up. Latency is set by the two reciprocal
// multiplications of the encode path, each followed by a register.
// When the receiver stalls, the result holds on m_axis and empty stages
// behind it keep filling; s_axis_tready falls only once all five stages
// hold beats. No beat is lost or repeated.
// Reset clears all stage valid bits; the pipeline is then empty and ready.
`default_nettype none
`include "frame_index_bcd_msf_convert_core_defines.svh"

module frame_index_bcd_msf_convert_core
    import msf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [19:0] frame_index, [27:20] minute_bcd, [35:28] second_bcd,
    // [43:36] frame_bcd, [47:44] zero
    input  wire logic [47:0] s_axis_tdata,
    // [0] req_type
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [20:0] index_out, [28:21] minute_bcd_out, [35:29] second_bcd_out,
    // [42:36] frame_bcd_out, [47:43] zero
    output logic [47:0]      m_axis_tdata
);

    logic [4:0]     valid_reg;
    logic [4:0]     valid_next;
    logic [4:0]     ready;
    msf_req_t       mode_reg [4];
    msf_ld_t        ld;
    logic [6:0]     enc_minutes;
    logic [5:0]     enc_seconds;
    logic [6:0]     enc_frames;
    logic [20:0]    dec_index;
    logic [20:0]    index_out_reg;
    logic [7:0]     minute_out_reg;
    logic [6:0]     second_out_reg;
    logic [6:0]     frame_out_reg;
    logic [7:0]     sec_packed;
    logic [7:0]     frame_packed;

    always_comb
    begin
        ready[4] = !valid_reg[4] || m_axis_tready;
        ready[3] = !valid_reg[3] || ready[4];
        ready[2] = !valid_reg[2] || ready[3];
        ready[1] = !valid_reg[1] || ready[2];
        ready[0] = !valid_reg[0] || ready[1];

        valid_next[0] = ready[0] ? s_axis_tvalid : valid_reg[0];
        valid_next[1] = ready[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = ready[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = ready[3] ? valid_reg[2] : valid_reg[3];
        valid_next[4] = ready[4] ? valid_reg[3] : valid_reg[4];
    end

    assign ld.s1 = ready[0];
    assign ld.s2 = ready[1];
    assign ld.s3 = ready[2];
    assign ld.s4 = ready[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            mode_reg[0] <= msf_req_t'(s_axis_tuser);
        end
        if (ld.s2)
        begin
            mode_reg[1] <= mode_reg[0];
        end
        if (ld.s3)
        begin
            mode_reg[2] <= mode_reg[1];
        end
        if (ld.s4)
        begin
            mode_reg[3] <= mode_reg[2];
        end
    end

    msf_encode u_encode (
        .clk         (clk),
        .ld          (ld),
        .frame_index (s_axis_tdata[19:0]),
        .minutes     (enc_minutes),
        .seconds     (enc_seconds),
        .frames      (enc_frames)
    );

    msf_decode u_decode (
        .clk        (clk),
        .ld         (ld),
        .minute_bcd (s_axis_tdata[27:20]),
        .second_bcd (s_axis_tdata[35:28]),
        .frame_bcd  (s_axis_tdata[43:36]),
        .index_out  (dec_index)
    );

    assign sec_packed   = pack_bcd(7'(enc_seconds));
    assign frame_packed = pack_bcd(enc_frames);

    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            unique case (mode_reg[3])
                REQ_ENCODE:
                begin
                    index_out_reg  <= '0;
                    minute_out_reg <= pack_bcd(enc_minutes);
                    second_out_reg <= sec_packed[6:0];
                    frame_out_reg  <= frame_packed[6:0];
                end
                REQ_DECODE:
                begin
                    index_out_reg  <= dec_index;
                    minute_out_reg <= '0;
                    second_out_reg <= '0;
                    frame_out_reg  <= '0;
                end
                default:
                begin
                    index_out_reg  <= '0;
                    minute_out_reg <= '0;
                    second_out_reg <= '0;
                    frame_out_reg  <= '0;
                end
            endcase
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[4];
    assign m_axis_tdata  = {5'd0, frame_out_reg, second_out_reg, minute_out_reg,
                            index_out_reg};

    `MSF_ASSERT_NOW(a_ready_only_when_full, clk, rst_n, !s_axis_tready,
        (valid_reg == 5'b11111) && m_axis_tvalid && !m_axis_tready,
        "input stalled while the pipeline has room")

    `MSF_ASSERT_NOW(a_seconds_digit, clk, rst_n, m_axis_tvalid,
        m_axis_tdata[35:33] <= 3'd5 && m_axis_tdata[32:29] <= 4'd9,
        "encoded seconds are not valid BCD below 60")

    `MSF_ASSERT_NOW(a_unused_fields_zero, clk, rst_n, m_axis_tvalid,
        (m_axis_tdata[20:0] == 21'd0) || (m_axis_tdata[42:21] == 22'd0),
        "both result kinds driven in one beat")

    `MSF_ASSERT_NEXT(a_beat_advances, clk, rst_n, valid_reg[3] && ready[4],
        m_axis_tvalid, "stage four beat did not reach the output")

endmodule

`default_nettype wire

@@ sim/frame_index_bcd_msf_convert_core_tb.sv @@
`default_nettype none

module frame_index_bcd_msf_convert_core_tb;

    localparam int LEAD_IN_FRAMES     = 150;
    localparam int LAST_ABS_FRAME     = 449999;
    localparam int FRAMES_PER_SECOND  = 75;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int LIMIT_CYCLES       = 400000;
    localparam int DRAIN_CYCLES       = 12;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_RANDOM,
        FLOW_HEAVY
    } flow_mode_t;

    // Laid out exactly as m_axis_tdata, most significant field first.
    typedef struct packed {
        logic [4:0]  pad;
        logic [6:0]  frame;
        logic [6:0]  second;
        logic [7:0]  minute;
        logic [20:0] index;
    } msf_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    wire logic   m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire logic [47:0] m_axis_tdata;

    msf_result_t expected_q[$];
    flow_mode_t  sender_mode = FLOW_RANDOM;
    flow_mode_t  sink_mode = FLOW_RANDOM;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          encode_count = 0;
    int          decode_count = 0;
    int          clamped_count = 0;
    int          non_decimal_count = 0;
    int          result_count = 0;

    frame_index_bcd_msf_convert_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("frame_index_bcd_msf_convert_core test failed");
        $finish;
    end

    function automatic logic [7:0] to_bcd(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic int from_bcd(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic msf_result_t predict_conversion(input msf_pkg::msf_req_t req,
                                                       input logic [19:0] idx,
                                                       input logic [7:0] mb,
                                                       input logic [7:0] sb,
                                                       input logic [7:0] fb);
        msf_result_t r;
        int x;
        int secs;
        int total;
        r = '0;
        if (req == msf_pkg::REQ_ENCODE)
        begin
            x = int'($signed(idx)) + LEAD_IN_FRAMES;
            if (x < 0)
                x = 0;
            if (x > LAST_ABS_FRAME)
                x = LAST_ABS_FRAME;
            secs = x / FRAMES_PER_SECOND;
            r.minute = to_bcd(secs / SECONDS_PER_MINUTE);
            r.second = 7'(to_bcd(secs % SECONDS_PER_MINUTE));
            r.frame  = 7'(to_bcd(x % FRAMES_PER_SECOND));
        end
        else
        begin
            total = FRAMES_PER_SECOND * (SECONDS_PER_MINUTE * from_bcd(mb) + from_bcd(sb))
                    + from_bcd(fb) - LEAD_IN_FRAMES;
            r.index = 21'(total);
        end
        return r;
    endfunction

    function automatic int pick_gap(input flow_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == FLOW_FREE || r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    task automatic send_request(input msf_pkg::msf_req_t req, input logic [19:0] idx,
                                input logic [7:0] mb, input logic [7:0] sb,
                                input logic [7:0] fb);
        int gap;
        int x;
        gap = pick_gap(sender_mode);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {4'd0, fb, sb, mb, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_q.push_back(predict_conversion(req, idx, mb, sb, fb));
        if (req == msf_pkg::REQ_ENCODE)
        begin
            encode_count++;
            x = int'($signed(idx)) + LEAD_IN_FRAMES;
            if (x < 0 || x > LAST_ABS_FRAME)
                clamped_count++;
        end
        else
        begin
            decode_count++;
            if (mb[7:4] > 9 || mb[3:0] > 9 || sb[7:4] > 9 || sb[3:0] > 9 ||
                fb[7:4] > 9 || fb[3:0] > 9)
                non_decimal_count++;
        end
    endtask

    task automatic send_encode(input int frame_index);
        send_request(msf_pkg::REQ_ENCODE, 20'(frame_index), 8'($urandom), 8'($urandom),
                     8'($urandom));
    endtask

    task automatic send_decode(input logic [7:0] mb, input logic [7:0] sb,
                               input logic [7:0] fb);
        send_request(msf_pkg::REQ_DECODE, 20'($urandom), mb, sb, fb);
    endtask

    task automatic send_random_request();
        int r;
        int x;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0)
        begin
            if (r < 75)
            begin
                send_encode($urandom_range(0, LAST_ABS_FRAME) - LEAD_IN_FRAMES);
            end
            else if (r < 90)
            begin
                case ($urandom_range(0, 3))
                    0: x = $urandom_range(0, 3);
                    1: x = LAST_ABS_FRAME - $urandom_range(0, 3);
                    2: x = $urandom_range(1, 99) * 4500 + $urandom_range(0, 2) - 1;
                    default: x = $urandom_range(1, 5999) * 75 + $urandom_range(0, 2) - 1;
                endcase
                send_encode(x - LEAD_IN_FRAMES);
            end
            else
            begin
                send_encode(int'($signed(20'($urandom))));
            end
        end
        else
        begin
            if (r < 80)
                send_decode(to_bcd($urandom_range(0, 99)), to_bcd($urandom_range(0, 59)),
                            to_bcd($urandom_range(0, 74)));
            else
                send_decode(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_encode_edges();
        send_encode(-LEAD_IN_FRAMES);
        send_encode(-LEAD_IN_FRAMES - 1);
        send_encode(-524288);
        send_encode(524287);
        send_encode(LAST_ABS_FRAME - LEAD_IN_FRAMES);
        send_encode(LAST_ABS_FRAME - LEAD_IN_FRAMES + 1);
        send_encode(74 - LEAD_IN_FRAMES);
        send_encode(75 - LEAD_IN_FRAMES);
        send_encode(4499 - LEAD_IN_FRAMES);
        send_encode(4500 - LEAD_IN_FRAMES);
        send_encode(0);
        send_encode(-1);
    endtask

    task automatic test_decode_edges();
        send_decode(8'h00, 8'h00, 8'h00);
        send_decode(8'h00, 8'h02, 8'h00);
        send_decode(8'h99, 8'h59, 8'h74);
        send_decode(8'hFF, 8'hFF, 8'hFF);
        send_decode(8'h0A, 8'h0F, 8'hF0);
        send_decode(8'hA5, 8'h5A, 8'h99);
        send_decode(8'h00, 8'h01, 8'h74);
    endtask

    task automatic test_mixed_random(input int count);
        sender_mode = FLOW_RANDOM;
        sink_mode   = FLOW_RANDOM;
        for (int i = 0; i < count; i++)
        begin
            send_random_request();
            if (i == count / 2)
                wait_results_drained();
        end
    endtask

    task automatic test_full_rate(input int count);
        sender_mode = FLOW_FREE;
        sink_mode   = FLOW_FREE;
        for (int i = 0; i < count; i++)
            send_random_request();
    endtask

    task automatic test_output_backpressure(input int count);
        sender_mode = FLOW_FREE;
        sink_mode   = FLOW_HEAVY;
        for (int i = 0; i < count; i++)
            send_random_request();
    endtask

    initial
    begin
        int hold;
        int r;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_mode == FLOW_FREE)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if ((sink_mode == FLOW_HEAVY) ? (r < 35) : (r < 70))
                begin
                    m_axis_tready <= 1'b1;
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        msf_result_t want;
        msf_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            result_count++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("index_out", 32'(want.index), 32'(got.index));
                check_field("minute_bcd_out", 32'(want.minute), 32'(got.minute));
                check_field("second_bcd_out", 32'(want.second), 32'(got.second));
                check_field("frame_bcd_out", 32'(want.frame), 32'(got.frame));
                check_field("padding", 32'(want.pad), 32'(got.pad));
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_edges();
        test_decode_edges();
        wait_results_drained();
        test_mixed_random(700);
        test_full_rate(200);
        test_output_backpressure(200);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results: %0d encode requests (%0d clamped) and %0d decode",
                 result_count, encode_count, clamped_count, decode_count);
        $display("requests (%0d with non-decimal digits), under random and full-rate flow.",
                 non_decimal_count);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("frame_index_bcd_msf_convert_core test passed");
        else
            $display("frame_index_bcd_msf_convert_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
